FILE: hw/rtl/usb_control_endpoint_sequencer_assert.svh
// Assertion macros used by the sequencer RTL.
`ifndef USB_CONTROL_ENDPOINT_SEQUENCER_ASSERT_SVH
`define USB_CONTROL_ENDPOINT_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define USBCS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("usbcs: same-cycle check failed");

// next-cycle implication
`define USBCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("usbcs: next-cycle check failed");

`endif

FILE: hw/rtl/usbcs_pkg.sv
package usbcs_pkg;

  // event kinds
  localparam logic [1:0] FN_BUS_RESET = 2'd0;
  localparam logic [1:0] FN_SETUP     = 2'd1;
  localparam logic [1:0] FN_POLL      = 2'd2;
  localparam logic [1:0] FN_IN_DONE   = 2'd3;

  // actions
  localparam logic [1:0] ACT_NONE      = 2'd0;
  localparam logic [1:0] ACT_WRITE     = 2'd1;
  localparam logic [1:0] ACT_SET_ADDR  = 2'd2;
  localparam logic [1:0] ACT_CONFIGURE = 2'd3;

  // data sources
  localparam logic [2:0] SRC_NONE       = 3'd0;
  localparam logic [2:0] SRC_DEVICE     = 3'd1;
  localparam logic [2:0] SRC_CONFIG     = 3'd2;
  localparam logic [2:0] SRC_HID_REPORT = 3'd3;
  localparam logic [2:0] SRC_MOUSE      = 3'd4;

  // device states
  localparam logic [1:0] DEV_DEFAULT    = 2'd0;
  localparam logic [1:0] DEV_ADDRESSED  = 2'd1;
  localparam logic [1:0] DEV_CONFIGURED = 2'd2;

  // setup decoding
  localparam logic [6:0] RT_STD_DEVICE  = 7'h00;
  localparam logic [6:0] RT_STD_IFACE   = 7'h01;
  localparam logic [6:0] RT_CLASS_IFACE = 7'h21;
  localparam logic [7:0] REQ_SET_ADDRESS    = 8'h05;
  localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'h06;
  localparam logic [7:0] REQ_SET_CONFIG     = 8'h09;
  localparam logic [7:0] REQ_SET_IDLE       = 8'h0A;
  localparam logic [7:0] DT_DEVICE     = 8'h01;
  localparam logic [7:0] DT_CONFIG     = 8'h02;
  localparam logic [7:0] DT_HID_REPORT = 8'h22;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_EP0_MPS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HID_EP       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HID_EP_TYPE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HID_EP_MPS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HID_DESC_LEN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HID_RPT_LEN  = 3'd5;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [5:0] {
    STG_SETUP       = 6'b000001,
    STG_DATA_IN     = 6'b000010,
    STG_DATA_IN_IDLE = 6'b000100,
    STG_DATA_IN_ZERO = 6'b001000,
    STG_STATUS_OUT  = 6'b010000,
    STG_STATUS_IN   = 6'b100000
  } stage_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  target_endpoint;
    logic [2:0]  source;
    logic [15:0] source_offset;
    logic [6:0]  packet_length;
    logic [6:0]  device_address;
    logic [1:0]  endpoint_type;
    logic [1:0]  device_state_out;
    logic [2:0]  stage_out;
    logic        last;
  } res_t;

  // one event's results; r1 is valid only with two set
  typedef struct packed {
    res_t r0;
    res_t r1;
    logic two;
  } entry_t;

  function automatic logic [2:0] stage_code(input stage_t s);
    logic [2:0] c;
    c = 3'd0;
    unique case (s)
      STG_SETUP:        c = 3'd0;
      STG_DATA_IN:      c = 3'd1;
      STG_DATA_IN_IDLE: c = 3'd2;
      STG_DATA_IN_ZERO: c = 3'd3;
      STG_STATUS_OUT:   c = 3'd4;
      STG_STATUS_IN:    c = 3'd5;
      default:          c = 3'd0;
    endcase
    return c;
  endfunction

endpackage

FILE: hw/rtl/usb_control_endpoint_sequencer.sv
// Channel | Handshake           | Payload
// in      | in_valid / in_stall | func, request_type, request_code, request_value,
//         |                     | request_length, endpoint
// out     | out_valid/out_stall | action .. last (one or two results per item)
// cfg     | cfg_write           | cfg_index, cfg_data
//
// An event is accepted every cycle while the two-entry queue has room; its
// results are built and state updated in the cycle it is accepted.
// Results leave one per cycle while out_stall is low: one result for most events,
// two for SET_CONFIGURATION and an IN completion that sends a ZLP and a report.
// Results are registered in the queue before they appear. Reset is synchronous.
// A held out_stall fills the queue, then raises in_stall.
`include "usb_control_endpoint_sequencer_assert.svh"

module usb_control_endpoint_sequencer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [usbcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [usbcs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        func,
  input  logic [7:0]                        request_type,
  input  logic [7:0]                        request_code,
  input  logic [15:0]                       request_value,
  input  logic [15:0]                       request_length,
  input  logic [3:0]                        endpoint,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        action,
  output logic [3:0]                        target_endpoint,
  output logic [2:0]                        source,
  output logic [15:0]                       source_offset,
  output logic [6:0]                        packet_length,
  output logic [6:0]                        device_address,
  output logic [1:0]                        endpoint_type,
  output logic [1:0]                        device_state_out,
  output logic [2:0]                        stage_out,
  output logic                              last
);

  usbcs_pkg::entry_t new_entry;
  usbcs_pkg::entry_t head;
  usbcs_pkg::res_t   result;
  logic accept;
  logic full;
  logic empty;
  logic pop;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  usbcs_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .accept         (accept),
    .func           (func),
    .request_type   (request_type),
    .request_code   (request_code),
    .request_value  (request_value),
    .request_length (request_length),
    .endpoint       (endpoint),
    .entry          (new_entry)
  );

  usbcs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_entry (new_entry),
    .pop        (pop),
    .head       (head),
    .full       (full),
    .empty      (empty)
  );

  usbcs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .result    (result),
    .pop       (pop)
  );

  assign action           = result.action;
  assign target_endpoint  = result.target_endpoint;
  assign source           = result.source;
  assign source_offset    = result.source_offset;
  assign packet_length    = result.packet_length;
  assign device_address   = result.device_address;
  assign endpoint_type    = result.endpoint_type;
  assign device_state_out = result.device_state_out;
  assign stage_out        = result.stage_out;
  assign last             = result.last;

  // a stalled input means a full queue, so results are waiting
  `USBCS_ASSERT_NOW(a_stall_has_output, clk, rst, in_stall, out_valid)
  // a taken non-final result is followed by the second one
  `USBCS_ASSERT_NEXT(a_second_follows, clk, rst, out_valid && !out_stall && !last, out_valid)
  // only a configure or a ZLP opens a two-result event
  `USBCS_ASSERT_NOW(a_first_of_two, clk, rst, out_valid && !last,
    action == usbcs_pkg::ACT_CONFIGURE ||
    (action == usbcs_pkg::ACT_WRITE && source == usbcs_pkg::SRC_NONE))
  // a configure action is always followed by its HID endpoint ZLP
  `USBCS_ASSERT_NOW(a_configure_not_last, clk, rst,
    out_valid && action == usbcs_pkg::ACT_CONFIGURE, !last)

endmodule

FILE: hw/rtl/usbcs_front.sv
module usbcs_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [usbcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [usbcs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              accept,
  input  logic [1:0]                        func,
  input  logic [7:0]                        request_type,
  input  logic [7:0]                        request_code,
  input  logic [15:0]                       request_value,
  input  logic [15:0]                       request_length,
  input  logic [3:0]                        endpoint,
  output usbcs_pkg::entry_t                 entry
);

  // configuration registers
  logic [6:0] ep0_max_packet;
  logic [3:0] hid_endpoint;
  logic [1:0] hid_ep_type;
  logic [6:0] hid_ep_max_packet;
  logic [7:0] hid_report_desc_length;
  logic [6:0] hid_report_length;

  // transfer state
  usbcs_pkg::stage_t stage, stage_next;
  logic [15:0] remaining, remaining_next;
  logic [2:0]  data_source, data_source_next;
  logic [15:0] data_offset, data_offset_next;
  logic [1:0]  dev_state, dev_state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      ep0_max_packet         <= 7'd64;
      hid_endpoint           <= 4'd1;
      hid_ep_type            <= 2'd3;
      hid_ep_max_packet      <= 7'd8;
      hid_report_desc_length <= 8'd50;
      hid_report_length      <= 7'd4;
    end else if (cfg_write) begin
      case (cfg_index)
        usbcs_pkg::CFG_EP0_MPS:      ep0_max_packet         <= cfg_data[6:0];
        usbcs_pkg::CFG_HID_EP:       hid_endpoint           <= cfg_data[3:0];
        usbcs_pkg::CFG_HID_EP_TYPE:  hid_ep_type            <= cfg_data[1:0];
        usbcs_pkg::CFG_HID_EP_MPS:   hid_ep_max_packet      <= cfg_data[6:0];
        usbcs_pkg::CFG_HID_DESC_LEN: hid_report_desc_length <= cfg_data;
        usbcs_pkg::CFG_HID_RPT_LEN:  hid_report_length      <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage       <= usbcs_pkg::STG_SETUP;
      remaining   <= 16'd0;
      data_source <= usbcs_pkg::SRC_NONE;
      data_offset <= 16'd0;
      dev_state   <= usbcs_pkg::DEV_DEFAULT;
    end else if (accept) begin
      stage       <= stage_next;
      remaining   <= remaining_next;
      data_source <= data_source_next;
      data_offset <= data_offset_next;
      dev_state   <= dev_state_next;
    end
  end

  // classify the event and build its results
  always_comb begin
    logic [6:0]  rtype;
    logic [7:0]  dtype;
    logic [6:0]  chunk;
    logic        zlp;
    logic        rpt;
    usbcs_pkg::res_t r0, r1;
    logic        two;

    rtype = request_type[6:0];
    dtype = request_value[15:8];
    chunk = (remaining < {9'd0, ep0_max_packet}) ? remaining[6:0] : ep0_max_packet;
    zlp   = (remaining == 16'd0) && (stage == usbcs_pkg::STG_DATA_IN_ZERO);
    rpt   = (endpoint == hid_endpoint);

    stage_next       = stage;
    remaining_next   = remaining;
    data_source_next = data_source;
    data_offset_next = data_offset;
    dev_state_next   = dev_state;
    r0  = '0;
    r1  = '0;
    two = 1'b0;

    unique case (func)
      usbcs_pkg::FN_BUS_RESET: begin
        remaining_next = 16'd0;
        dev_state_next = usbcs_pkg::DEV_DEFAULT;
        stage_next     = usbcs_pkg::STG_SETUP;
        r0.action      = usbcs_pkg::ACT_SET_ADDR;
      end
      usbcs_pkg::FN_SETUP: begin
        if (rtype == usbcs_pkg::RT_STD_DEVICE) begin
          if (request_code == usbcs_pkg::REQ_GET_DESCRIPTOR) begin
            if (dtype == usbcs_pkg::DT_DEVICE || dtype == usbcs_pkg::DT_CONFIG) begin
              data_source_next = dtype[2:0];
              data_offset_next = 16'd0;
              remaining_next   = request_length;
              stage_next       = usbcs_pkg::STG_DATA_IN;
            end
          end else if (request_code == usbcs_pkg::REQ_SET_ADDRESS) begin
            r0.action         = usbcs_pkg::ACT_SET_ADDR;
            r0.device_address = request_value[6:0];
            dev_state_next    = usbcs_pkg::DEV_ADDRESSED;
            stage_next        = usbcs_pkg::STG_STATUS_IN;
          end else if (request_code == usbcs_pkg::REQ_SET_CONFIG) begin
            r0.action          = usbcs_pkg::ACT_CONFIGURE;
            r0.target_endpoint = hid_endpoint;
            r0.packet_length   = hid_ep_max_packet;
            r0.endpoint_type   = hid_ep_type;
            r1.action          = usbcs_pkg::ACT_WRITE;
            r1.target_endpoint = hid_endpoint;
            two                = 1'b1;
            dev_state_next     = usbcs_pkg::DEV_CONFIGURED;
            stage_next         = usbcs_pkg::STG_STATUS_IN;
          end
        end else if (rtype == usbcs_pkg::RT_CLASS_IFACE) begin
          if (request_code == usbcs_pkg::REQ_SET_IDLE) begin
            stage_next = usbcs_pkg::STG_STATUS_IN;
          end
        end else if (rtype == usbcs_pkg::RT_STD_IFACE) begin
          if (request_code == usbcs_pkg::REQ_GET_DESCRIPTOR &&
              dtype == usbcs_pkg::DT_HID_REPORT) begin
            data_source_next = usbcs_pkg::SRC_HID_REPORT;
            data_offset_next = 16'd0;
            remaining_next   = {8'd0, hid_report_desc_length};
            stage_next       = usbcs_pkg::STG_DATA_IN;
          end
        end
      end
      usbcs_pkg::FN_POLL: begin
        if (stage == usbcs_pkg::STG_DATA_IN) begin
          r0.action        = usbcs_pkg::ACT_WRITE;
          r0.source        = data_source;
          r0.source_offset = data_offset;
          r0.packet_length = chunk;
          remaining_next   = remaining - {9'd0, chunk};
          data_offset_next = data_offset + {9'd0, chunk};
          if (remaining_next != 16'd0) begin
            stage_next = usbcs_pkg::STG_DATA_IN_IDLE;
          end else if (chunk == ep0_max_packet) begin
            // final chunk was full: a zero-length packet must follow
            stage_next = usbcs_pkg::STG_DATA_IN_ZERO;
          end else begin
            stage_next = usbcs_pkg::STG_STATUS_OUT;
          end
        end else if (stage == usbcs_pkg::STG_STATUS_OUT) begin
          stage_next = usbcs_pkg::STG_SETUP;
        end else if (stage == usbcs_pkg::STG_STATUS_IN) begin
          r0.action  = usbcs_pkg::ACT_WRITE;
          stage_next = usbcs_pkg::STG_SETUP;
        end
      end
      usbcs_pkg::FN_IN_DONE: begin
        if (remaining != 16'd0) begin
          stage_next = usbcs_pkg::STG_DATA_IN;
        end else if (zlp) begin
          stage_next = usbcs_pkg::STG_STATUS_OUT;
        end
        if (zlp) begin
          r0.action = usbcs_pkg::ACT_WRITE;
          if (rpt) begin
            r1.action          = usbcs_pkg::ACT_WRITE;
            r1.target_endpoint = endpoint;
            r1.source          = usbcs_pkg::SRC_MOUSE;
            r1.packet_length   = hid_report_length;
            two                = 1'b1;
          end
        end else if (rpt) begin
          r0.action          = usbcs_pkg::ACT_WRITE;
          r0.target_endpoint = endpoint;
          r0.source          = usbcs_pkg::SRC_MOUSE;
          r0.packet_length   = hid_report_length;
        end
      end
      default: ;
    endcase

    r0.device_state_out = dev_state_next;
    r0.stage_out        = usbcs_pkg::stage_code(stage_next);
    r0.last             = !two;
    r1.device_state_out = dev_state_next;
    r1.stage_out        = usbcs_pkg::stage_code(stage_next);
    r1.last             = 1'b1;

    entry.r0  = r0;
    entry.r1  = r1;
    entry.two = two;
  end

endmodule

FILE: hw/rtl/usbcs_queue.sv
module usbcs_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  usbcs_pkg::entry_t push_entry,
  input  logic              pop,
  output usbcs_pkg::entry_t head,
  output logic              full,
  output logic              empty
);

  usbcs_pkg::entry_t mem [usbcs_pkg::QUEUE_DEPTH];
  logic [usbcs_pkg::QPTR_W-1:0] wr_ptr;
  logic [usbcs_pkg::QPTR_W-1:0] rd_ptr;
  logic [usbcs_pkg::QCNT_W-1:0] count;

  localparam logic [usbcs_pkg::QCNT_W-1:0] DEPTH_CNT =
    usbcs_pkg::QCNT_W'(usbcs_pkg::QUEUE_DEPTH);
  localparam logic [usbcs_pkg::QPTR_W-1:0] LAST_PTR =
    usbcs_pkg::QPTR_W'(usbcs_pkg::QUEUE_DEPTH - 1);

  assign full  = (count == DEPTH_CNT);
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/usbcs_back.sv
module usbcs_back (
  input  logic              clk,
  input  logic              rst,
  input  usbcs_pkg::entry_t head,
  input  logic              empty,
  input  logic              out_stall,
  output logic              out_valid,
  output usbcs_pkg::res_t   result,
  output logic              pop
);

  // 0: first result of the head entry, 1: second
  logic phase;
  logic taken;

  assign out_valid = !empty;
  assign result    = phase ? head.r1 : head.r0;
  assign taken     = out_valid && !out_stall;
  assign pop       = taken && result.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else if (taken) begin
      phase <= !result.last;
    end
  end

endmodule
